// File: src/ssib_pkg.sv
// Shared types and constants for the split sorted insertion buffer.
package ssib_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [7:0] TYPE_A = 8'd65;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic STORE_A = 1'b0;
    localparam logic STORE_B = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic signed [31:0] product_code;
        logic [7:0]        product_type;
    } req_t;

    typedef struct packed {
        logic              from_store;
        logic signed [31:0] out_code;
        logic [7:0]        out_type;
        logic              record_valid;
        logic              overflowed;
        logic              last;
    } res_t;

    typedef struct packed {
        logic signed [31:0] code;
        logic [7:0]        kind;
    } rec_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } ctl_t;

endpackage

// File: src/ssib_cell.sv
// One slot of a sorted chain: compare with the key, shift right on insert, left on drain.
module ssib_cell
    import ssib_pkg::*;
(
    input  logic clk,
    input  ctl_t ctl,
    input  logic occupied,
    input  logic prev_less,
    input  rec_t key,
    input  rec_t left,
    input  rec_t right,
    output rec_t data,
    output logic less
);

    rec_t data_reg;
    rec_t data_next;

    assign less = occupied && (data_reg.code < key.code);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins && !less)
        begin
            data_next = prev_less ? key : left;
        end
        else if (ctl.shift)
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: src/ssib_chain.sv
// Row of cells forming one sorted store, with its fill count.
module ssib_chain
    import ssib_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  rec_t             key,
    output rec_t             head,
    output logic [CNT_W-1:0] count
);

    rec_t             cell_data [STORE_DEPTH];
    logic             cell_less [STORE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    genvar i;
    generate
        for (i = 0; i < STORE_DEPTH; i++)
        begin : g_cell
            rec_t left_data;
            rec_t right_data;
            logic prev_less;
            if (i == 0)
            begin : g_first
                assign left_data = key;
                assign prev_less = 1'b1;
            end
            else
            begin : g_rest
                assign left_data = cell_data[i-1];
                assign prev_less = cell_less[i-1];
            end
            if (i == STORE_DEPTH - 1)
            begin : g_end
                assign right_data = cell_data[i];
            end
            else
            begin : g_mid
                assign right_data = cell_data[i+1];
            end
            ssib_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (CNT_W'(i) < count_reg),
                .prev_less (prev_less),
                .key       (key),
                .left      (left_data),
                .right     (right_data),
                .data      (cell_data[i]),
                .less      (cell_less[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head = cell_data[0];
    assign count = count_reg;

endmodule

// File: src/split_sorted_insertion_buffer_top.sv
// Top level of the split sorted insertion buffer: two sorted chains and the drain sequencer.
//
// Requests enter on start/request and are taken at a rising edge with start high
// and busy low. An insert request files the record into chain A (type 'A') or
// chain B (any other type), ahead of equal codes; busy stays low, so inserts
// may follow every cycle. An insert into a full chain is dropped and
// sets the sticky overflow flag.
// A drain request raises busy and shifts one record out of the chain heads per
// cycle, store A first, then store B: the first result is registered from the
// chain heads once busy is set, and busy is held until the last record has been
// shifted out, after which the next request can be taken. A drain with both
// stores empty gives one result with an invalid record on the cycle after the
// request and leaves busy low. Each result is on result for one
// cycle with strobe high; the receiver cannot stall it. The last result carries
// last; every result carries the overflow flag as it stood before the drain,
// and the flag is cleared when the drain ends.
// Reset empties both stores, clears the flag and drops busy; no clearing pass
// is needed, so requests are taken as soon as reset is released.
module split_sorted_insertion_buffer_top
    import ssib_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic strobe,
    output res_t result
);

    logic             busy_reg;
    logic             busy_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             strobe_reg;
    logic             strobe_next;
    res_t             result_reg;
    res_t             result_next;
    ctl_t             ctl_a;
    ctl_t             ctl_b;
    rec_t             key;
    rec_t             head_a;
    rec_t             head_b;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic             accept;
    logic             is_a;
    logic             one_left;

    assign accept = start && !busy_reg;
    assign is_a = (request.product_type == TYPE_A);
    assign key.code = request.product_code;
    assign key.kind = request.product_type;
    assign one_left = ((count_a == CNT_W'(1)) && (count_b == '0))
                   || ((count_a == '0) && (count_b == CNT_W'(1)));

    always_comb
    begin
        busy_next = busy_reg;
        ovf_next = ovf_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        ctl_a = '0;
        ctl_b = '0;
        if (busy_reg)
        begin
            strobe_next = 1'b1;
            result_next.record_valid = 1'b1;
            result_next.overflowed = ovf_reg;
            result_next.last = one_left;
            if (count_a != '0)
            begin
                ctl_a.shift = 1'b1;
                result_next.from_store = STORE_A;
                result_next.out_code = head_a.code;
                result_next.out_type = head_a.kind;
            end
            else
            begin
                ctl_b.shift = 1'b1;
                result_next.from_store = STORE_B;
                result_next.out_code = head_b.code;
                result_next.out_type = head_b.kind;
            end
            if (one_left)
            begin
                busy_next = 1'b0;
                ovf_next = 1'b0;
            end
        end
        else if (accept)
        begin
            case (request.req_type)
                REQ_INSERT:
                begin
                    if (is_a)
                    begin
                        if (count_a == CNT_W'(STORE_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ctl_a.ins = 1'b1;
                        end
                    end
                    else
                    begin
                        if (count_b == CNT_W'(STORE_DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ctl_b.ins = 1'b1;
                        end
                    end
                end
                REQ_DRAIN:
                begin
                    if ((count_a == '0) && (count_b == '0))
                    begin
                        strobe_next = 1'b1;
                        result_next.from_store = STORE_A;
                        result_next.out_code = '0;
                        result_next.out_type = '0;
                        result_next.record_valid = 1'b0;
                        result_next.overflowed = ovf_reg;
                        result_next.last = 1'b1;
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovf_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovf_reg <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    ssib_chain u_chain_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_a),
        .key   (key),
        .head  (head_a),
        .count (count_a)
    );

    ssib_chain u_chain_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_b),
        .key   (key),
        .head  (head_b),
        .count (count_b)
    );

    assign busy = busy_reg;
    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_busy_has_records: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((count_a != '0) || (count_b != '0)))
        else $error("drain active with both stores empty");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> ((count_a == '0) && (count_b == '0) && !ovf_reg))
        else $error("stores not empty after final drain result");

    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(busy_reg || (start && (request.req_type == REQ_DRAIN))))
        else $error("result without a drain");

    a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (count_a != '0)) |=> (strobe_reg && (result_reg.from_store == STORE_A)))
        else $error("store B emitted before store A was empty");
`endif

endmodule

// File: dv/split_sorted_insertion_buffer_top_tb.sv
// Self-checking testbench for the split sorted insertion buffer: directed table, then random requests.
module split_sorted_insertion_buffer_top_tb
    import ssib_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_SETTLE = 2 * STORE_DEPTH + 8;
    localparam int RANDOM_REQUESTS = 300;

    typedef struct {
        req_t req;
        bit   typed;
        res_t want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic strobe;
    res_t result;

    logic signed [31:0] sorted_a[$];
    rec_t               sorted_b[$];
    logic               overflow_seen;
    res_t               drained[$];
    res_t               due_records[$];
    int                 mismatches = 0;
    int                 burst_left = 0;
    int                 quiet_cycles = 0;

    split_sorted_insertion_buffer_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .strobe(strobe),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void file_record(req_t r);
        int p;
        logic signed [31:0] key;
        logic signed [31:0] probe;
        key = r.product_code;
        p = 0;
        if (r.product_type == TYPE_A)
        begin
            if (sorted_a.size() >= STORE_DEPTH)
                overflow_seen = 1'b1;
            else
            begin
                while (p < sorted_a.size())
                begin
                    probe = sorted_a[p];
                    if (probe >= key)
                        break;
                    p++;
                end
                sorted_a.insert(p, key);
            end
        end
        else
        begin
            if (sorted_b.size() >= STORE_DEPTH)
                overflow_seen = 1'b1;
            else
            begin
                while (p < sorted_b.size())
                begin
                    probe = sorted_b[p].code;
                    if (probe >= key)
                        break;
                    p++;
                end
                sorted_b.insert(p, rec_t'{key, r.product_type});
            end
        end
    endfunction

    function automatic void drain_stores();
        int total;
        int k;
        total = sorted_a.size() + sorted_b.size();
        k = 0;
        drained.delete();
        if (total == 0)
            drained.push_back(res_t'{STORE_A, 32'sd0, 8'd0, 1'b0, overflow_seen, 1'b1});
        foreach (sorted_a[i])
        begin
            k++;
            drained.push_back(res_t'{STORE_A, sorted_a[i], TYPE_A, 1'b1, overflow_seen,
                                     k == total});
        end
        foreach (sorted_b[i])
        begin
            k++;
            drained.push_back(res_t'{STORE_B, sorted_b[i].code, sorted_b[i].kind, 1'b1,
                                     overflow_seen, k == total});
        end
        sorted_a.delete();
        sorted_b.delete();
        overflow_seen = 1'b0;
    endfunction

    function automatic req_t insert_req(logic signed [31:0] code, logic [7:0] kind);
        return req_t'{REQ_INSERT, code, kind};
    endfunction

    function automatic req_t drain_req();
        logic [31:0] noise_code;
        logic [7:0]  noise_kind;
        noise_code = $urandom;
        noise_kind = $urandom;
        return req_t'{REQ_DRAIN, noise_code, noise_kind};
    endfunction

    function automatic logic signed [31:0] random_code();
        logic signed [31:0] c;
        case ($urandom_range(0, 3))
            0: c = $urandom_range(0, 8) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: c = 32'sh8000_0000;
                    1: c = 32'sh7FFF_FFFF;
                    2: c = 32'sd0;
                    default: c = -32'sd1;
                endcase
            end
            default: c = $urandom;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] other_kind();
        logic [7:0] k;
        k = $urandom;
        if (k == TYPE_A)
            k = ~k;
        return k;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic issue(req_t r, bit typed, res_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        if (r.req_type == REQ_INSERT)
            file_record(r);
        else
        begin
            drain_stores();
            if (typed)
                due_records.push_back(want);
            else
                foreach (drained[i])
                    due_records.push_back(drained[i]);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && strobe)
        begin
            if (due_records.size() == 0)
            begin
                $display("%0t: record expected none got %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = due_records.pop_front();
                check_field("from_store", want.from_store, result.from_store);
                check_field("out_code", want.out_code, result.out_code);
                check_field("out_type", want.out_type, result.out_type);
                check_field("record_valid", want.record_valid, result.record_valid);
                check_field("overflowed", want.overflowed, result.overflowed);
                check_field("last", want.last, result.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** split_sorted_insertion_buffer_top: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        step_t opening[$];
        int    mode;
        int    n;
        int    random_sent;
        bit    target_a;
        logic [7:0] kind;

        overflow_seen = 1'b0;
        random_sent = 0;

        opening.push_back('{drain_req(), 1'b1,
                            res_t'{STORE_A, 32'sd0, 8'd0, 1'b0, 1'b0, 1'b1}});
        opening.push_back('{insert_req(32'sh8000_0000, TYPE_A), 1'b0, '0});
        opening.push_back('{drain_req(), 1'b1,
                            res_t'{STORE_A, 32'sh8000_0000, TYPE_A, 1'b1, 1'b0, 1'b1}});
        opening.push_back('{insert_req(32'sh7FFF_FFFF, 8'hFF), 1'b0, '0});
        opening.push_back('{drain_req(), 1'b1,
                            res_t'{STORE_B, 32'sh7FFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b1}});
        opening.push_back('{insert_req(32'sd0, 8'h00), 1'b0, '0});
        opening.push_back('{drain_req(), 1'b1,
                            res_t'{STORE_B, 32'sd0, 8'h00, 1'b1, 1'b0, 1'b1}});
        opening.push_back('{insert_req(32'sd5, TYPE_A), 1'b0, '0});
        opening.push_back('{insert_req(32'sd7, 8'h42), 1'b0, '0});
        opening.push_back('{insert_req(32'sd7, 8'h78), 1'b0, '0});
        opening.push_back('{insert_req(32'sd5, TYPE_A), 1'b0, '0});
        opening.push_back('{insert_req(-32'sd1, TYPE_A), 1'b0, '0});
        opening.push_back('{insert_req(-32'sd1, 8'h40), 1'b0, '0});
        opening.push_back('{insert_req(32'sh7FFF_FFFF, 8'h42), 1'b0, '0});
        opening.push_back('{insert_req(32'sh7FFF_FFFF, TYPE_A), 1'b0, '0});
        opening.push_back('{insert_req(32'sh8000_0000, TYPE_A), 1'b0, '0});
        opening.push_back('{insert_req(32'sd0, 8'h61), 1'b0, '0});
        opening.push_back('{insert_req(32'sh8000_0000, 8'hC3), 1'b0, '0});
        opening.push_back('{drain_req(), 1'b0, '0});
        opening.push_back('{drain_req(), 1'b1,
                            res_t'{STORE_A, 32'sd0, 8'd0, 1'b0, 1'b0, 1'b1}});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            issue(opening[i].req, opening[i].typed, opening[i].want);

        while (random_sent < RANDOM_REQUESTS)
        begin
            mode = $urandom_range(0, 11);
            target_a = $urandom_range(0, 1);
            if (mode == 0)
                n = 0;
            else if (mode == 1)
                n = $urandom_range(2 * STORE_DEPTH + 2, 2 * STORE_DEPTH + 8);
            else if (mode == 2)
                n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            else
                n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
            begin
                if (mode == 1)
                    kind = i[0] ? TYPE_A : other_kind();
                else if (mode == 2)
                    kind = target_a ? TYPE_A : other_kind();
                else
                    kind = $urandom_range(0, 1) ? TYPE_A : 8'($urandom);
                issue(insert_req(random_code(), kind), 1'b0, '0);
                random_sent++;
            end
            issue(drain_req(), 1'b0, '0);
            random_sent++;
        end

        start <= 1'b0;
        while (due_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("** split_sorted_insertion_buffer_top: PASSED **");
        else
            $display("** split_sorted_insertion_buffer_top: FAILED **");
        $finish;
    end

endmodule
